FILE: rtl/gasf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Global alignment score fill package
// Shared constants, codes and types of the score fill core.
// ----------------------------------------------------------------------------
package gasf_pkg;

    localparam int MAX_FIRST_LEN_DEF  = 32;
    localparam int MAX_SECOND_LEN_DEF = 1024;

    localparam int SYM_W   = 8;
    localparam int COEF_W  = 8;
    localparam int SCORE_W = 19;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 11;
    localparam int MASK_W  = 3;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_DATA_W = 40;

    localparam int SCORE_MAX = 262143;
    localparam int SCORE_MIN = -262144;

    localparam logic [COEF_W-1:0] GAP_RST      = 8'hFE;
    localparam logic [COEF_W-1:0] MATCH_RST    = 8'h01;
    localparam logic [COEF_W-1:0] MISMATCH_RST = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_COLUMN = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP      = 2'd0,
        CFG_MATCH    = 2'd1,
        CFG_MISMATCH = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_ROWS
    } t_state;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [MASK_W-1:0]         mask;
    } t_cell_res;

endpackage
`default_nettype wire

FILE: rtl/gasf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gasf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

FILE: rtl/gasf_cell_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Score cell unit
// Forms the diagonal, up and left candidates of one cell, picks the best,
// builds the tie mask and saturates the score.
// ----------------------------------------------------------------------------
module gasf_cell_unit (
    input  wire logic signed [gasf_pkg::SCORE_W-1:0] i_diag,
    input  wire logic signed [gasf_pkg::SCORE_W-1:0] i_up,
    input  wire logic signed [gasf_pkg::SCORE_W-1:0] i_left,
    input  wire logic        [gasf_pkg::SYM_W-1:0]   i_sym_a,
    input  wire logic        [gasf_pkg::SYM_W-1:0]   i_sym_b,
    input  wire logic signed [gasf_pkg::COEF_W-1:0]  i_match,
    input  wire logic signed [gasf_pkg::COEF_W-1:0]  i_mismatch,
    input  wire logic signed [gasf_pkg::COEF_W-1:0]  i_gap,
    output gasf_pkg::t_cell_res                       o_res
);

    localparam int EW = gasf_pkg::SCORE_W + 1;
    localparam logic signed [EW-1:0] E_MAX = EW'(gasf_pkg::SCORE_MAX);
    localparam logic signed [EW-1:0] E_MIN = EW'(gasf_pkg::SCORE_MIN);

    logic signed [gasf_pkg::COEF_W-1:0] sub;
    logic signed [EW-1:0] cand_d;
    logic signed [EW-1:0] cand_u;
    logic signed [EW-1:0] cand_l;
    logic signed [EW-1:0] best_du;
    logic signed [EW-1:0] best;

    always_comb begin
        sub     = (i_sym_a == i_sym_b) ? i_match : i_mismatch;
        cand_d  = EW'(i_diag) + EW'(sub);
        cand_u  = EW'(i_up) + EW'(i_gap);
        cand_l  = EW'(i_left) + EW'(i_gap);
        best_du = (cand_u > cand_d) ? cand_u : cand_d;
        best    = (cand_l > best_du) ? cand_l : best_du;

        o_res.mask = {cand_l == best, cand_u == best, cand_d == best};
        if (best > E_MAX) begin
            o_res.score = gasf_pkg::SCORE_W'(E_MAX);
        end else if (best < E_MIN) begin
            o_res.score = gasf_pkg::SCORE_W'(E_MIN);
        end else begin
            o_res.score = gasf_pkg::SCORE_W'(best);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/global_alignment_score_fill_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Global alignment score fill core
// Linear gap score fill: stores the first sequence, fills one matrix column
// per second-sequence symbol and streams every filled cell.
//
//  Channel  | Direction | Payload
//  ---------+-----------+---------------------------------------------------
//  s stream | in        | tdata: symbol; tuser: kind
//  m stream | out       | tdata: row, column, score, tie mask; tlast: last row
//  cfg      | in        | index and 8-bit data of the score registers
//
// A load, clear or ignored transaction completes in the idle state. A column
// transaction passes through the setup states MUL and SAT, which form and
// saturate the row 0 score on the small multiplier; then the cell unit and the
// previous-column memory handle one row per cycle unless the output stalls.
// A stalled output register freezes the row walk without losing a cell.
// Reset restores the default scores and empties both sequences; no memory
// clearing pass is needed.
// ----------------------------------------------------------------------------
module global_alignment_score_fill_core #(
    parameter int MAX_FIRST_LEN  = gasf_pkg::MAX_FIRST_LEN_DEF,
    parameter int MAX_SECOND_LEN = gasf_pkg::MAX_SECOND_LEN_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Bits 7:0 symbol.
    input  wire logic [gasf_pkg::SYM_W-1:0]          i_s_tdata,
    // Bits 1:0 kind.
    input  wire logic [gasf_pkg::KIND_W-1:0]         i_s_tuser,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // Bits 5:0 row_index, 16:6 column_index, 35:17 cell_score,
    // 38:36 from_mask, 39 zero.
    output logic [gasf_pkg::OUT_DATA_W-1:0]          o_m_tdata,
    output logic                                     o_m_tlast,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gasf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gasf_pkg::COEF_W-1:0]         i_cfg_data
);

    localparam int SW_ = gasf_pkg::SCORE_W;
    localparam int LW  = $clog2(MAX_FIRST_LEN + 1);
    localparam int AW  = (MAX_FIRST_LEN > 1) ? $clog2(MAX_FIRST_LEN) : 1;
    localparam int CW  = $clog2(MAX_SECOND_LEN + 1);
    localparam int PW  = CW + 9;
    localparam int XW  = (PW > 20) ? PW : 20;
    localparam int RXW = LW + gasf_pkg::ROW_W;
    localparam int CXW = CW + gasf_pkg::COL_W;
    localparam logic signed [XW-1:0] X_MAX = XW'(gasf_pkg::SCORE_MAX);
    localparam logic signed [XW-1:0] X_MIN = XW'(gasf_pkg::SCORE_MIN);

    gasf_pkg::t_state r_state;
    gasf_pkg::t_state n_state;

    logic signed [gasf_pkg::COEF_W-1:0] r_gap;
    logic signed [gasf_pkg::COEF_W-1:0] r_match;
    logic signed [gasf_pkg::COEF_W-1:0] r_mismatch;
    logic [LW-1:0]                      r_len;
    logic [CW-1:0]                      r_col;
    logic signed [SW_-1:0]              r_top;
    logic [gasf_pkg::SYM_W-1:0]         r_sym;
    logic [LW-1:0]                      r_row;
    logic signed [SW_-1:0]              r_diag;
    logic signed [SW_-1:0]              r_up;
    logic signed [SW_-1:0]              r_colz;
    logic                               r_init_col;
    logic signed [PW-1:0]               r_prod;

    logic                               r_out_valid;
    logic [gasf_pkg::ROW_W-1:0]         r_out_row;
    logic [gasf_pkg::COL_W-1:0]         r_out_col;
    logic signed [SW_-1:0]              r_out_score;
    logic [gasf_pkg::MASK_W-1:0]        r_out_mask;
    logic                               r_out_last;

    logic                        s_accept;
    gasf_pkg::t_kind             in_kind;
    logic                        load_wr;
    logic                        col_go;
    logic                        advance;
    logic                        last_cell;
    logic [LW-1:0]               row_p1;
    logic [LW-1:0]               rd_row;
    logic [CW-1:0]               col_p1;
    logic [RXW-1:0]              row_wide;
    logic [CXW-1:0]              col_wide;
    logic signed [XW-1:0]        prod_ext;
    logic signed [SW_-1:0]       top_sat;
    logic [gasf_pkg::SYM_W-1:0]  seq_rd;
    logic [SW_-1:0]              prev_rd;
    logic signed [SW_-1:0]       left_val;
    gasf_pkg::t_cell_res         cell_out;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign in_kind  = gasf_pkg::t_kind'(i_s_tuser);
    assign load_wr  = s_accept && (in_kind == gasf_pkg::KIND_LOAD) && (r_col == '0)
                      && (r_len < LW'(MAX_FIRST_LEN));
    assign col_go   = s_accept && (in_kind == gasf_pkg::KIND_COLUMN)
                      && (r_col < CW'(MAX_SECOND_LEN));
    assign row_p1   = r_row + LW'(1);
    assign col_p1   = r_col + CW'(1);
    assign last_cell = (row_p1 == r_len);
    assign row_wide = RXW'(row_p1);
    assign col_wide = CXW'(r_col);
    assign prod_ext = XW'(r_prod);
    assign left_val = r_init_col ? r_colz : $signed(prev_rd);

    always_comb begin
        if (prod_ext > X_MAX) begin
            top_sat = SW_'(X_MAX);
        end else if (prod_ext < X_MIN) begin
            top_sat = SW_'(X_MIN);
        end else begin
            top_sat = SW_'(prod_ext);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gasf_pkg::ST_IDLE: begin
                if (col_go) begin
                    n_state = gasf_pkg::ST_MUL;
                end
            end
            gasf_pkg::ST_MUL: begin
                n_state = gasf_pkg::ST_SAT;
            end
            gasf_pkg::ST_SAT: begin
                n_state = (r_len == '0) ? gasf_pkg::ST_IDLE : gasf_pkg::ST_ROWS;
            end
            gasf_pkg::ST_ROWS: begin
                if (advance && last_cell) begin
                    n_state = gasf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gasf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_tready = 1'b0;
        advance    = 1'b0;
        rd_row     = r_row;
        unique case (r_state)
            gasf_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            gasf_pkg::ST_ROWS: begin
                advance = !r_out_valid || i_m_tready;
                rd_row  = advance ? row_p1 : r_row;
            end
            default: begin
                advance = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap      <= gasf_pkg::GAP_RST;
            r_match    <= gasf_pkg::MATCH_RST;
            r_mismatch <= gasf_pkg::MISMATCH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (gasf_pkg::t_cfg_index'(i_cfg_index))
                gasf_pkg::CFG_GAP:      r_gap      <= i_cfg_data;
                gasf_pkg::CFG_MATCH:    r_match    <= i_cfg_data;
                gasf_pkg::CFG_MISMATCH: r_mismatch <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gasf_pkg::ST_IDLE;
            r_len       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_row       <= '0;
            r_init_col  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_wr) begin
                r_len <= r_len + LW'(1);
            end
            if (s_accept && (in_kind == gasf_pkg::KIND_CLEAR)) begin
                r_len <= '0;
                r_col <= '0;
                r_top <= '0;
            end
            if (col_go) begin
                r_row <= '0;
            end
            if (r_state == gasf_pkg::ST_MUL) begin
                r_col      <= col_p1;
                r_init_col <= (r_col == '0);
            end
            if (r_state == gasf_pkg::ST_SAT) begin
                r_top <= top_sat;
            end
            if (advance) begin
                r_row       <= row_p1;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (col_go) begin
            r_sym <= i_s_tdata;
        end
        if (r_state == gasf_pkg::ST_MUL) begin
            r_prod <= $signed({1'b0, col_p1}) * r_gap;
            r_diag <= r_top;
            r_colz <= SW_'(r_gap);
        end
        if (r_state == gasf_pkg::ST_SAT) begin
            r_up <= top_sat;
        end
        if (advance) begin
            r_diag      <= left_val;
            r_up        <= cell_out.score;
            r_colz      <= r_colz + SW_'(r_gap);
            r_out_row   <= row_wide[gasf_pkg::ROW_W-1:0];
            r_out_col   <= col_wide[gasf_pkg::COL_W-1:0];
            r_out_score <= cell_out.score;
            r_out_mask  <= cell_out.mask;
            r_out_last  <= last_cell;
        end
    end

    gasf_ram #(
        .WIDTH (gasf_pkg::SYM_W),
        .DEPTH (MAX_FIRST_LEN)
    ) u_seq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (load_wr),
        .i_wr_addr (r_len[AW-1:0]),
        .i_wr_data (i_s_tdata),
        .i_rd_addr (rd_row[AW-1:0]),
        .o_rd_data (seq_rd)
    );

    gasf_ram #(
        .WIDTH (SW_),
        .DEPTH (MAX_FIRST_LEN)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (advance),
        .i_wr_addr (r_row[AW-1:0]),
        .i_wr_data (cell_out.score),
        .i_rd_addr (rd_row[AW-1:0]),
        .o_rd_data (prev_rd)
    );

    gasf_cell_unit u_cell (
        .i_diag     (r_diag),
        .i_up       (r_up),
        .i_left     (left_val),
        .i_sym_a    (seq_rd),
        .i_sym_b    (r_sym),
        .i_match    (r_match),
        .i_mismatch (r_mismatch),
        .i_gap      (r_gap),
        .o_res      (cell_out)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {1'b0, r_out_mask, r_out_score, r_out_col, r_out_row};

endmodule
`default_nettype wire

FILE: rtl/gasf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Score fill port checker
// Watches the stream ports of the core and flags illegal behavior.
// ----------------------------------------------------------------------------
module gasf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic [gasf_pkg::KIND_W-1:0]     i_s_tuser,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [gasf_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                            o_m_tlast
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled result changed");

    // Every emitted cell has at least one predecessor reaching the maximum.
    a_mask_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[38:36] != 3'd0)
        else $error("empty tie mask");

    // After a load, clear or unknown transaction the input is ready again in the following cycle.
    a_short_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != gasf_pkg::KIND_COLUMN) |=> o_s_tready)
        else $error("non-column transaction kept the input stalled");

    // While a cell that is not the last of its column waits, the column is still busy.
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input accepted in the middle of a column");

endmodule

bind global_alignment_score_fill_core gasf_checker u_gasf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

FILE: tb/global_alignment_score_fill_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Global alignment score fill core testbench
// Drives load, column, clear and unknown transactions into the core and
// keeps its own column fill of the score matrix. Every emitted cell is
// compared field by field with the oldest predicted cell. Directed cases,
// register extremes, a long output hold-off and random sets under several
// idle patterns are run in turn.
// ----------------------------------------------------------------------------
module global_alignment_score_fill_core_test;
    import gasf_pkg::*;

    localparam int MAX_FIRST     = MAX_FIRST_LEN_DEF;
    localparam int MAX_SECOND    = MAX_SECOND_LEN_DEF;
    localparam int QUIET_CYCLES  = MAX_FIRST + 16;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    typedef struct {
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [SCORE_W-1:0] score;
        logic [MASK_W-1:0]         mask;
        logic                      last;
    } t_exp_cell;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [SYM_W-1:0]      i_s_tdata = '0;
    logic [KIND_W-1:0]     i_s_tuser = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COEF_W-1:0]     i_cfg_data = '0;

    // Score registers and column state of the predictor.
    logic signed [COEF_W-1:0] gap_score = GAP_RST;
    logic signed [COEF_W-1:0] match_gain = MATCH_RST;
    logic signed [COEF_W-1:0] mismatch_score = MISMATCH_RST;
    logic [SYM_W-1:0] first_symbols [MAX_FIRST];
    int kept_column [MAX_FIRST];
    int first_len = 0;
    int columns_done = 0;
    int top_score = 0;

    t_exp_cell expected_cells [$];
    int mismatch_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    global_alignment_score_fill_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp_score(longint v);
        if (v > SCORE_MAX) return SCORE_MAX;
        if (v < SCORE_MIN) return SCORE_MIN;
        return int'(v);
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        logic [SYM_W-1:0] alphabet [4];
        alphabet = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
        if ($urandom_range(9) < 7) return alphabet[$urandom_range(3)];
        return SYM_W'($urandom_range(255));
    endfunction

    task automatic clear_matrix();
        for (int r = 0; r < MAX_FIRST; r++) begin
            first_symbols[r] = '0;
            kept_column[r] = 0;
        end
        first_len = 0;
        columns_done = 0;
        top_score = 0;
    endtask

    task automatic fill_column(logic [SYM_W-1:0] sym);
        int g, diag, up, s;
        longint sub, d, u, l, m;
        t_exp_cell c;
        g = gap_score;
        if (columns_done == 0) begin
            for (int r = 0; r < first_len; r++)
                kept_column[r] = clamp_score(longint'(r + 1) * g);
        end
        diag = top_score;
        columns_done++;
        top_score = clamp_score(longint'(columns_done) * g);
        up = top_score;
        for (int r = 0; r < first_len; r++) begin
            sub = (first_symbols[r] == sym) ? match_gain : mismatch_score;
            d = longint'(diag) + sub;
            u = longint'(up) + g;
            l = longint'(kept_column[r]) + g;
            m = d;
            if (u > m) m = u;
            if (l > m) m = l;
            s = clamp_score(m);
            c.row = ROW_W'(r + 1);
            c.col = COL_W'(columns_done);
            c.score = SCORE_W'(s);
            c.mask = {l == m, u == m, d == m};
            c.last = (r + 1 == first_len);
            expected_cells.insert(expected_cells.size(), c);
            diag = kept_column[r];
            kept_column[r] = s;
            up = s;
        end
    endtask

    task automatic apply_item(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym);
        case (kind)
            KIND_LOAD: begin
                if (columns_done == 0 && first_len < MAX_FIRST) begin
                    first_symbols[first_len] = sym;
                    first_len++;
                end
            end
            KIND_COLUMN: begin
                if (columns_done < MAX_SECOND) fill_column(sym);
            end
            KIND_CLEAR: clear_matrix();
            default: ;
        endcase
    endtask

    task automatic check_cell(logic [OUT_DATA_W-1:0] data, logic last);
        t_exp_cell want;
        if (expected_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected cell row %0d col %0d score %0d mask %b last %b",
                         $realtime, data[5:0], data[16:6], $signed(data[35:17]),
                         data[38:36], last);
            return;
        end
        want = expected_cells.pop_front();
        if (data[5:0] !== want.row || data[16:6] !== want.col ||
            data[35:17] !== want.score || data[38:36] !== want.mask ||
            data[39] !== 1'b0 || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display({"%0t: cell mismatch, expected row %0d col %0d score %0d mask %b ",
                          "last %b, got row %0d col %0d score %0d mask %b last %b pad %b"},
                         $realtime, want.row, want.col, want.score, want.mask, want.last,
                         data[5:0], data[16:6], $signed(data[35:17]), data[38:36], last,
                         data[39]);
        end
    endtask

    // Predicts on every accepted input or register transaction and checks each
    // accepted output transaction, all from values sampled at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) apply_item(i_s_tuser, i_s_tdata);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAP:      gap_score = i_cfg_data;
                    CFG_MATCH:    match_gain = i_cfg_data;
                    CFG_MISMATCH: mismatch_score = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_m_tvalid && i_m_tready) check_cell(o_m_tdata, o_m_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym);
        if ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_s_tdata <= sym;
        i_s_tuser <= kind;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_scores(logic [COEF_W-1:0] gap, logic [COEF_W-1:0] match,
                              logic [COEF_W-1:0] mismatch);
        t_cfg_index regs [3];
        logic [COEF_W-1:0] vals [3];
        regs = '{CFG_GAP, CFG_MATCH, CFG_MISMATCH};
        vals = '{gap, match, mismatch};
        wait_quiet();
        for (int i = 0; i < 3; i++) begin
            i_cfg_index <= regs[i];
            i_cfg_data <= vals[i];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_and_fill(int len, int ncols);
        send_item(KIND_CLEAR, SYM_W'($urandom_range(255)));
        repeat (len) send_item(KIND_LOAD, pick_symbol());
        repeat (ncols) send_item(KIND_COLUMN, pick_symbol());
    endtask

    task automatic test_directed_cases();
        gap_pct = 0;
        stall_pct = 0;
        send_item(KIND_COLUMN, 8'h00);
        send_item(KIND_LOAD, 8'h11);
        send_item(KIND_UNKNOWN, 8'hFF);
        send_item(KIND_CLEAR, 8'hFF);
        send_item(KIND_LOAD, 8'h00);
        send_item(KIND_LOAD, 8'hFF);
        send_item(KIND_LOAD, 8'h5A);
        send_item(KIND_LOAD, 8'hA5);
        send_item(KIND_COLUMN, 8'hFF);
        send_item(KIND_COLUMN, 8'h00);
        send_item(KIND_COLUMN, 8'h5A);
        send_item(KIND_COLUMN, 8'h33);
        send_item(KIND_LOAD, 8'h77);
        send_item(KIND_UNKNOWN, 8'h00);
        send_item(KIND_COLUMN, 8'hA5);
        send_item(KIND_CLEAR, 8'h00);
        send_item(KIND_LOAD, 8'hFF);
        send_item(KIND_COLUMN, 8'hFF);
        send_item(KIND_CLEAR, 8'h5A);
    endtask

    task automatic test_first_sequence_full();
        gap_pct = 31;
        stall_pct = 31;
        load_and_fill(MAX_FIRST + 3, 2);
    endtask

    task automatic test_register_settings();
        logic [COEF_W-1:0] settings [5][3];
        settings = '{'{8'h80, 8'h7F, 8'h80}, '{8'h7F, 8'h80, 8'h7F},
                     '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'h01, 8'hFF},
                     '{8'hFD, 8'h02, 8'hFE}};
        gap_pct = 0;
        stall_pct = 0;
        foreach (settings[i]) begin
            set_scores(settings[i][0], settings[i][1], settings[i][2]);
            load_and_fill(6, 3);
        end
        // New scores take effect on the next column; kept scores stay as they are.
        set_scores(8'h83, 8'h05, 8'h7E);
        repeat (2) send_item(KIND_COLUMN, pick_symbol());
    endtask

    task automatic test_backpressure_hold();
        set_scores(8'hFE, 8'h01, 8'hFF);
        gap_pct = 0;
        stall_pct = 0;
        send_item(KIND_CLEAR, 8'h00);
        repeat (MAX_FIRST) send_item(KIND_LOAD, pick_symbol());
        hold_left = 400;
        repeat (6) send_item(KIND_COLUMN, pick_symbol());
    endtask

    task automatic run_random_sets(int target);
        int sent, len, ncols;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(99) < 85) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(MAX_FIRST + 3, 1)
                                               : $urandom_range(8, 0);
                ncols = $urandom_range(8, 1);
                send_item(KIND_CLEAR, SYM_W'($urandom_range(255)));
                repeat (len) send_item(KIND_LOAD, pick_symbol());
                repeat (ncols) begin
                    if ($urandom_range(9) == 0) begin
                        if ($urandom_range(1) == 0) send_item(KIND_UNKNOWN, pick_symbol());
                        else send_item(KIND_LOAD, pick_symbol());
                    end
                    send_item(KIND_COLUMN, pick_symbol());
                end
                sent += 1 + len + ncols;
            end else begin
                repeat ($urandom_range(4, 1))
                    send_item(KIND_W'($urandom_range(3)), SYM_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random_phases();
        int phase_gap [4];
        int phase_stall [4];
        phase_gap = '{0, 60, 0, 31};
        phase_stall = '{0, 0, 60, 31};
        for (int p = 0; p < 4; p++) begin
            set_scores(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
            gap_pct = phase_gap[p];
            stall_pct = phase_stall[p];
            run_random_sets(33);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_first_sequence_full();
        test_register_settings();
        test_backpressure_hold();
        test_random_phases();
        wait_quiet();
        if (mismatch_count == 0 && expected_cells.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
